// File: src/assert_macros.svh
// Assertion helpers shared by the cipher RTL.
// TSFC_ASSERT checks a property outside reset, TSFC_ASSERT_ALWAYS checks it
// on every edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TSFC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cipher assertion failed");
`define TSFC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cipher assertion failed");
`else
`define TSFC_ASSERT(lbl, clk, rst, prop)
`define TSFC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: src/tsfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfc_pkg
// Types, sizes and constant tables of the two-S-box Feistel cipher.
// ----------------------------------------------------------------------------
package tsfc_pkg;

  localparam int KEY_BYTES_MAX = 56;
  localparam int KC_W          = $clog2(KEY_BYTES_MAX + 1);
  localparam int KA_W          = $clog2(KEY_BYTES_MAX);
  localparam int NROUNDS       = 16;
  localparam int NSUB          = NROUNDS + 2;
  localparam int SK_W          = $clog2(NSUB);
  localparam int SCHED_BYTES   = NSUB * 4;
  localparam int SB_W          = $clog2(SCHED_BYTES);
  localparam int WRAP_W        = $clog2(SCHED_BYTES + 1);
  localparam int SBOX_DEPTH    = 256;
  localparam int DERIVE_STEPS  = NSUB / 2 + SBOX_DEPTH;
  localparam int DV_W          = $clog2(DERIVE_STEPS);
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [1:0] MODE_KEY  = 2'd0;
  localparam logic [1:0] MODE_ENC  = 2'd1;
  localparam logic [1:0] MODE_DEC  = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [2:0] ADDR_OLD_KEY_SCHEDULE = 3'd0;

  typedef enum logic [1:0] {
    OP_KEY = 2'd0,
    OP_ENC = 2'd1,
    OP_DEC = 2'd2
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [31:0] left;
    logic [31:0] right;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  localparam logic [31:0] INIT_P [NSUB] = '{
    32'h243A6A88, 32'h85C308D3, 32'h17198A2E, 32'h03787344, 32'hA9093822, 32'h499F31D0,
    32'h082E6A98, 32'hEC3E6C89, 32'hC52821E6, 32'h38D013F7, 32'hBE5E66CF, 32'h54E90C6C,
    32'hC0A329B7, 32'hC57C50DD, 32'h3F84DDB5, 32'hB5440917, 32'h9218D5D9, 32'h8379FB1B
  };

  localparam logic [31:0] INIT_S0 [SBOX_DEPTH] = '{
    32'hA1310BA6, 32'h38DFB5AC, 32'h4FFD72DB, 32'h501ADFB7, 32'hA8E1AFED, 32'h6A257E96,
    32'hBA7C9045, 32'hF12C7F99, 32'h24A19947, 32'hB3916CF7, 32'h0801F2E2, 32'h858EFC16,
    32'h636920D8, 32'h71574E69, 32'hA458FEA3, 32'hF4933D7E, 32'h0D95748F, 32'h728EB658,
    32'h718BCD58, 32'h82154AEE, 32'h7B54A41D, 32'hC25A59B5, 32'h9C30D539, 32'h2AF26013,
    32'hC5D1B023, 32'h286085F0, 32'hCA417918, 32'hB8DB38EF, 32'h8E79DCB0, 32'h603A180E,
    32'h6C9E0E8B, 32'hB01E8A3E, 32'hD71577C1, 32'hBD314B27, 32'h78AF2FDA, 32'h55605C60,
    32'hE65525F3, 32'hAA55AB94, 32'h57489862, 32'h63E81440, 32'h55CA396A, 32'h2AAB10B6,
    32'hB4CC5C34, 32'h1141E8CE, 32'hA15486AF, 32'h7C72E993, 32'hB3EE1411, 32'h636FBC2A,
    32'h2BA9C55D, 32'h741831F6, 32'hCE5C3E16, 32'h9B87931E, 32'hAFD6BA33, 32'h6C24CF5C,
    32'h7A325381, 32'h28958677, 32'h3B8F4898, 32'h6B4BB9AF, 32'hC4BFE81B, 32'h66282193,
    32'h61D809CC, 32'hFB21A991, 32'h487CAC60, 32'h5DEC8032, 32'hEF845D5D, 32'hE98575B1,
    32'hDC262302, 32'hEB651B88, 32'h23893E81, 32'hD396ACC5, 32'h0F6D6FF3, 32'h83F44239,
    32'h2E0B4482, 32'hA4842004, 32'h69C8F04A, 32'h9E1F9B5E, 32'h21C66842, 32'hF6E96C9A,
    32'h670C9C61, 32'hABD388F0, 32'h6A51A0D2, 32'hD8542F68, 32'h960FA728, 32'hAB5133A3,
    32'h6EEF0B6C, 32'h137A3BE4, 32'hBA3BF050, 32'h7EFB2A98, 32'hA1F1651D, 32'h39AF0176,
    32'h66CA593E, 32'h82430E88, 32'h8CEE8619, 32'h456F9FB4, 32'h7D84A5C3, 32'h3B8B5EBE,
    32'hE06F75D8, 32'h85C12073, 32'h401A449F, 32'h56C16AA6, 32'h4ED3AA62, 32'h363F7706,
    32'h1BFEDF72, 32'h429B023D, 32'h37D0D724, 32'hD00A1248, 32'hDB0FEAD3, 32'h49F1C09B,
    32'h075372C9, 32'h80991B7B, 32'h25D479D8, 32'hF6E8DEF7, 32'hE3FE501A, 32'hB6794C3B,
    32'h976CE0BD, 32'h04C006BA, 32'hC1A94FB6, 32'h409F60C4, 32'h5E5C9EC2, 32'h196A2463,
    32'h68FB6FAF, 32'h3E6C53B5, 32'h1339B2EB, 32'h3B52EC6F, 32'h6DFC511F, 32'h9B30952C,
    32'hCC814544, 32'hAF5EBD09, 32'hBEE3D004, 32'hDE334AFD, 32'h660F2807, 32'h192E4BB3,
    32'hC0CBA857, 32'h45C8740F, 32'hD20B5F39, 32'hB9D3FBDB, 32'h5579C0BD, 32'h1A60320A,
    32'hD6A100C6, 32'h402C7279, 32'h679F25FE, 32'hFB1FA3CC, 32'h8EA5E9F8, 32'hDB3222F8,
    32'h3C7516DF, 32'hFD616B15, 32'h2F501EC8, 32'hAD0552AB, 32'h323DB5FA, 32'hFD238760,
    32'h53317B48, 32'h3E00DF82, 32'h9E5C57BB, 32'hCA6F8CA0, 32'h1A87562E, 32'hDF1769DB,
    32'hD542A8F6, 32'h287EFFC3, 32'hAC6732C6, 32'h8C4F5573, 32'h695B27B0, 32'hBBCA58C8,
    32'hE1FFA35D, 32'hB8F011A0, 32'h10FA3D98, 32'hFD2183B8, 32'h4AFCB56C, 32'h2DD1D35B,
    32'h9A53E479, 32'hB6F84565, 32'hD28E49BC, 32'h4BFB9790, 32'hE1DDF2DA, 32'hA4CB7E33,
    32'h62FB1341, 32'hCEE4C6E8, 32'hEF20CADA, 32'h36774C01, 32'hD07E9EFE, 32'h2BF11FB4,
    32'h95DBDA4D, 32'hAE909198, 32'hEAAD8E71, 32'h6B93D5A0, 32'hD08ED1D0, 32'hAFC725E0,
    32'h8E3C5B2F, 32'h8E7594B7, 32'h8FF6E2FB, 32'hF2122B64, 32'h8888B812, 32'h900DF01C,
    32'h4FAD5EA0, 32'h688FC31C, 32'hD1CFF191, 32'hB3A8C1AD, 32'h2F2F2218, 32'hBE0E1777,
    32'hEA752DFE, 32'h8B021FA1, 32'hE5A0CC0F, 32'hB56F74E8, 32'h18ACF3D6, 32'hCE89E299,
    32'hB4A84FE0, 32'hFD13E0B7, 32'h7CC43B81, 32'hD2ADA8D9, 32'h165FA266, 32'h80957705,
    32'h93CC7314, 32'h211A1477, 32'hE6AD2065, 32'h77B5FA86, 32'hC75442F5, 32'hFB9D35CF,
    32'hEBCDAF0C, 32'h7B3E89A0, 32'hD6411BD3, 32'hAE1E7E49, 32'h00250E2D, 32'h2071B35E,
    32'h226800BB, 32'h57B8E0AF, 32'h2464369B, 32'hF009B91E, 32'h5563911D, 32'h59DFA6AA,
    32'h78C14389, 32'hD95A537F, 32'h207D5BA2, 32'h02E5B9C5, 32'h83260376, 32'h6295CFA9,
    32'h11C81968, 32'h4E734A41, 32'hB3472DCA, 32'h7B14A94A, 32'h1B510052, 32'h9A532915,
    32'hD60F573F, 32'hBC9BC6E4, 32'h2B60A476, 32'h81E67400, 32'h08BA6FB5, 32'h571BE91F,
    32'hF296EC6B, 32'h2A0DD915, 32'hB6636521, 32'hE7B9F9B6, 32'hFF34052E, 32'hC5855664,
    32'h53B02D5D, 32'hA99F8FA1, 32'h08BA4799, 32'h6E85076A
  };

  localparam logic [31:0] INIT_S1 [SBOX_DEPTH] = '{
    32'h3A39CE37, 32'hD3FAF5CF, 32'hABC27737, 32'h5AC52D1B, 32'h5CB0679E, 32'h4FA33742,
    32'hD3822740, 32'h99BC9BBE, 32'hD5118E9D, 32'hBF0F7315, 32'hD62D1C7E, 32'hC700C47B,
    32'hB78C1B6B, 32'h21A19045, 32'hB26EB1BE, 32'h6A366EB4, 32'h5748AB2F, 32'hBC946E79,
    32'hC6A376D2, 32'h6549C2C8, 32'h530FF8EE, 32'h468DDE7D, 32'hD5730A1D, 32'h4CD04DC6,
    32'h2939BBDB, 32'hA9BA4650, 32'hAC9526E8, 32'hBE5EE304, 32'hA1FAD5F0, 32'h6A2D519A,
    32'h63EF8CE2, 32'h9A86EE22, 32'hC089C2B8, 32'h43242EF6, 32'hA51E03AA, 32'h9CF2D0A4,
    32'h83C061BA, 32'h9BE96A4D, 32'h8FE51550, 32'hBA645BD6, 32'h2826A2F9, 32'hA73A3AE1,
    32'h4BA99586, 32'hEF5562E9, 32'hC72FEFD3, 32'hF752F7DA, 32'h3F046F69, 32'h77FA0A59,
    32'h80E4A915, 32'h87B08601, 32'h9B09E6AD, 32'h3B3EE593, 32'hE990FD5A, 32'h9E34D797,
    32'h2CF0B7D9, 32'h022B8B51, 32'h96D5AC3A, 32'h017DA67D, 32'hD1CF3ED6, 32'h7C7D2D28,
    32'h1F9F25CF, 32'hADF2B89B, 32'h5AD6B472, 32'h5A88F54C, 32'hE029AC71, 32'hE019A5E6,
    32'h47B0ACFD, 32'hED93FA9B, 32'hE8D3C48D, 32'h283B57CC, 32'hF8D56629, 32'h79132E28,
    32'h785F0191, 32'hED756055, 32'hF7960E44, 32'hE3D35E8C, 32'h15056DD4, 32'h88F46DBA,
    32'h03A16125, 32'h0564F0BD, 32'hC3EB9E15, 32'h3C9057A2, 32'h97271AEC, 32'hA93A072A,
    32'h1B3F6D9B, 32'h1E6321F5, 32'hF59C66FB, 32'h26DCF319, 32'h7533D928, 32'hB155FDF5,
    32'h03563482, 32'h8ABA3CBB, 32'h28517711, 32'hC20AD9F8, 32'hABCC5167, 32'hCCAD925F,
    32'h4DE81751, 32'h3830DC8E, 32'h379D5862, 32'h9320F991, 32'hEA7A90C2, 32'hFB3E7BCE,
    32'h5121CE64, 32'h774FBE32, 32'hA8B6E37E, 32'hC3293D46, 32'h48DE5369, 32'h6413E680,
    32'hA2AE0810, 32'hDD6DB224, 32'h69852DFD, 32'h09072166, 32'hB39A460A, 32'h6445C0DD,
    32'h586CDECF, 32'h1C20C8AE, 32'h5BBEF7DD, 32'h1B588D40, 32'hCCD2017F, 32'h6BB4E3BB,
    32'hDDA26A7E, 32'h3A59FF45, 32'h3E350A44, 32'hBCB4CDD5, 32'h72EACEA8, 32'hFA6484BB,
    32'h8D6612AE, 32'hBF3C6F47, 32'hD29BE463, 32'h542F5D9E, 32'hAEC2771B, 32'hF64E6370,
    32'h740E0D8D, 32'hE75B1357, 32'hF8721671, 32'hAF537D5D, 32'h4040CB08, 32'h4EB4E2CC,
    32'h34D2466A, 32'h0115AF84, 32'hE1B00428, 32'h95983A1D, 32'h06B89FB4, 32'hCE6EA048,
    32'h6F3F3B82, 32'h3520AB82, 32'h011A1D4B, 32'h277227F8, 32'h611560B1, 32'hE7933FDC,
    32'hBB3A792B, 32'h344525BD, 32'hA08839E1, 32'h51CE794B, 32'h2F32C9B7, 32'hA01FBAC9,
    32'hE01CC87E, 32'hBCC7D1F6, 32'hCF0111C3, 32'hA1E8AAC7, 32'h1A908749, 32'hD44FBD9A,
    32'hD0DADECB, 32'hD50ADA38, 32'h0339C32A, 32'hC6913667, 32'h8DF9317C, 32'hE0B12B4F,
    32'hF79E59B7, 32'h43F5BB3A, 32'hF2D519FF, 32'h27D9459C, 32'hBF97222C, 32'h15E6FC2A,
    32'h0F91FC71, 32'h9B941525, 32'hFAE59361, 32'hCEB69CEB, 32'hC2A86459, 32'h12BAA8D1,
    32'hB6C1075E, 32'hE3056A0C, 32'h10D25065, 32'hCB03A442, 32'hE0EC6E0E, 32'h1698DB3B,
    32'h4C98A0BE, 32'h3278E964, 32'h9F1F9532, 32'hE0D392DF, 32'hD3A0342B, 32'h8971F21E,
    32'h1B0A7441, 32'h4BA3348C, 32'hC5BE7120, 32'hC37632D8, 32'hDF359F8D, 32'h9B992F2E,
    32'hE60B6F47, 32'h0FE3F11D, 32'hE54CDA54, 32'h1EDAD891, 32'hCE6279CF, 32'hCD3E7E6F,
    32'h1618B166, 32'hFD2C1D05, 32'h848FD2C5, 32'hF6FB2299, 32'hF523F357, 32'hA6327623,
    32'h93A83531, 32'h56CCCD02, 32'hACF08162, 32'h5A75EBB5, 32'h6E163697, 32'h88D273CC,
    32'hDE966292, 32'h81B949D0, 32'h4C50901B, 32'h71C65614, 32'hE6C6C7BD, 32'h327A140A,
    32'h45E1D006, 32'hC3F27B9A, 32'hC9AA53FD, 32'h62A80F00, 32'hBB25BFE2, 32'h35BDD2F6,
    32'h71126905, 32'hB2040222, 32'hB6CBCF7C, 32'hCD769C2B, 32'h53113EC0, 32'h1640E3D3,
    32'h38ABBD60, 32'h2547ADF0, 32'hBA38209C, 32'hF746CE76, 32'h77AFA1C5, 32'h20756060,
    32'h85CBFE4E, 32'h8AE88DD8, 32'h7AAAF9B0, 32'h4CF9AA7E, 32'h1948C25C, 32'h02FB8A8C,
    32'h01C36AE4, 32'hD6EBE1F9, 32'h90D4F869, 32'hA65CDEA0, 32'h3F09252D, 32'hC208E69F,
    32'hB74E6132, 32'hCE77E25B, 32'h578FDFE3, 32'h3AC372E6
  };

endpackage

// File: src/tsfc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/tsfc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfc_queue
// Short request queue between the front end and the cipher core.
// ----------------------------------------------------------------------------
module tsfc_queue
  import tsfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head       = slots[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

// File: src/tsfc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfc_front
// Input side: accept stream requests, decode the mode, queue valid ones.
// ----------------------------------------------------------------------------
module tsfc_front
  import tsfc_pkg::*;
(
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        s_tlast,
  input  q_stat_t     q_stat,
  input  logic        clearing,
  output logic        push,
  output cmd_t        push_cmd
);

  logic accept;

  // hold off while the queue is full or the tables are being loaded after reset
  assign s_tready = !q_stat.full && !clearing;
  assign accept   = s_tvalid && s_tready;

  // drop the unused mode, it has no effect
  assign push = accept && (s_tuser != MODE_NONE);

  always_comb begin
    case (s_tuser)
      MODE_ENC: push_cmd.op = OP_ENC;
      MODE_DEC: push_cmd.op = OP_DEC;
      default:  push_cmd.op = OP_KEY;
    endcase
    push_cmd.key_byte = s_tdata[7:0];
    push_cmd.key_last = s_tlast;
    push_cmd.left     = s_tdata[39:8];
    push_cmd.right    = s_tdata[71:40];
  end

endmodule

// File: src/tsfc_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// tsfc_core
// Round engine, key schedule sequencer, tables and result register.
// ----------------------------------------------------------------------------
module tsfc_core
  import tsfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        old_key_schedule,
  input  q_stat_t     q_stat,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        clearing,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,
  output logic        m_tuser
);

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_KEYRD  = 10'b0000000100,
    ST_KEYMIX = 10'b0000001000,
    ST_RA     = 10'b0000010000,
    ST_RB     = 10'b0000100000,
    ST_FIN    = 10'b0001000000,
    ST_WRL    = 10'b0010000000,
    ST_WRR    = 10'b0100000000,
    ST_OUT    = 10'b1000000000
  } state_t;

  state_t            state;
  logic [7:0]        clr_cnt;
  logic              expand;
  logic [KC_W-1:0]   key_count;
  logic [KC_W-1:0]   key_len;
  logic [KC_W-1:0]   pos;
  logic [WRAP_W-1:0] wraps;
  logic [SB_W-1:0]   bcnt;
  logic [31:0]       acc;
  logic [31:0]       subkeys [NSUB];
  logic [31:0]       l;
  logic [31:0]       r;
  logic              dir;
  logic [3:0]        round;
  logic [DV_W-1:0]   didx;
  logic              out_kind;

  logic [SK_W-1:0]   sidx;
  logic [31:0]       lx;
  logic [31:0]       f;
  logic [31:0]       s0a_q, s0b_q, s1a_q, s1b_q;
  logic [7:0]        kdata;
  logic [31:0]       acc_next;
  logic [KC_W-1:0]   pos_inc;
  logic              wrap;
  logic [WRAP_W-1:0] wraps_next;
  logic [31:0]       mixed;
  logic [DV_W-1:0]   sb_j;
  logic [8:0]        sb_e;
  logic              wr_phase;
  logic              sb_phase;
  logic [31:0]       wr_word;
  logic              s0_we, s1_we;
  logic [7:0]        s0_waddr, s1_waddr;
  logic [31:0]       s0_wdata, s1_wdata;
  logic              key_we;
  logic              key_room;

  assign clearing = (state == ST_CLEAR) && !expand;
  assign q_pop    = (state == ST_IDLE) && !q_stat.empty;
  assign key_room = key_count < KC_W'(KEY_BYTES_MAX);
  assign key_we   = q_pop && (q_cmd.op == OP_KEY) && key_room;

  // round datapath
  assign sidx = dir ? (SK_W'(NSUB - 1) - SK_W'(round)) : SK_W'(round);
  assign lx   = l ^ subkeys[sidx];
  assign f    = ((s0a_q + s1a_q) ^ s1b_q) + s0b_q;

  // key schedule
  assign acc_next   = {acc[23:0], kdata};
  assign pos_inc    = pos + KC_W'(1);
  assign wrap       = pos_inc >= key_len;
  assign wraps_next = wraps + WRAP_W'(wrap);
  assign mixed      = INIT_P[bcnt[SB_W-1:2]] ^ acc_next ^
                      (old_key_schedule ? 32'd0 : 32'(wraps_next));

  // table writes during derivation
  assign sb_j     = didx - DV_W'(NSUB / 2);
  assign sb_e     = {sb_j[7:0], (state == ST_WRR)};
  assign wr_phase = (state == ST_WRL) || (state == ST_WRR);
  assign sb_phase = didx >= DV_W'(NSUB / 2);
  assign wr_word  = (state == ST_WRR) ? r : l;

  always_comb begin
    if (state == ST_CLEAR) begin
      s0_we    = 1'b1;
      s1_we    = 1'b1;
      s0_waddr = clr_cnt;
      s1_waddr = clr_cnt;
      s0_wdata = INIT_S0[clr_cnt];
      s1_wdata = INIT_S1[clr_cnt];
    end else begin
      s0_we    = wr_phase && sb_phase && !sb_e[8];
      s1_we    = wr_phase && sb_phase && sb_e[8];
      s0_waddr = sb_e[7:0];
      s1_waddr = sb_e[7:0];
      s0_wdata = wr_word;
      s1_wdata = wr_word;
    end
  end

  // each S-box is kept twice so that a round reads four words at once
  tsfc_ram #(.WIDTH(32), .DEPTH(SBOX_DEPTH)) u_s0a (
    .clk(clk), .we(s0_we), .waddr(s0_waddr), .wdata(s0_wdata),
    .raddr(lx[31:24]), .rdata(s0a_q)
  );
  tsfc_ram #(.WIDTH(32), .DEPTH(SBOX_DEPTH)) u_s0b (
    .clk(clk), .we(s0_we), .waddr(s0_waddr), .wdata(s0_wdata),
    .raddr(lx[7:0]), .rdata(s0b_q)
  );
  tsfc_ram #(.WIDTH(32), .DEPTH(SBOX_DEPTH)) u_s1a (
    .clk(clk), .we(s1_we), .waddr(s1_waddr), .wdata(s1_wdata),
    .raddr(lx[23:16]), .rdata(s1a_q)
  );
  tsfc_ram #(.WIDTH(32), .DEPTH(SBOX_DEPTH)) u_s1b (
    .clk(clk), .we(s1_we), .waddr(s1_waddr), .wdata(s1_wdata),
    .raddr(lx[15:8]), .rdata(s1b_q)
  );
  tsfc_ram #(.WIDTH(8), .DEPTH(KEY_BYTES_MAX)) u_key (
    .clk(clk), .we(key_we), .waddr(key_count[KA_W-1:0]), .wdata(q_cmd.key_byte),
    .raddr(pos[KA_W-1:0]), .rdata(kdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      expand    <= 1'b0;
      key_count <= '0;
      for (int i = 0; i < NSUB; i++) begin
        subkeys[i] <= INIT_P[i];
      end
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 8'd1;
          if (clr_cnt == 8'hFF) begin
            if (expand) begin
              pos   <= '0;
              wraps <= '0;
              bcnt  <= '0;
              acc   <= '0;
              state <= ST_KEYRD;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_IDLE: begin
          if (!q_stat.empty) begin
            if (q_cmd.op == OP_KEY) begin
              if (q_cmd.key_last) begin
                key_len   <= key_room ? key_count + KC_W'(1) : key_count;
                key_count <= '0;
                expand    <= 1'b1;
                clr_cnt   <= '0;
                state     <= ST_CLEAR;
              end else if (key_room) begin
                key_count <= key_count + KC_W'(1);
              end
            end else begin
              l        <= q_cmd.left;
              r        <= q_cmd.right;
              dir      <= (q_cmd.op == OP_DEC);
              round    <= '0;
              out_kind <= 1'b0;
              state    <= ST_RA;
            end
          end
        end
        ST_KEYRD: begin
          state <= ST_KEYMIX;
        end
        ST_KEYMIX: begin
          acc   <= acc_next;
          pos   <= wrap ? '0 : pos_inc;
          wraps <= wraps_next;
          if (bcnt[1:0] == 2'd3) begin
            subkeys[bcnt[SB_W-1:2]] <= mixed;
          end
          if (bcnt == SB_W'(SCHED_BYTES - 1)) begin
            l     <= '0;
            r     <= '0;
            dir   <= 1'b0;
            round <= '0;
            didx  <= '0;
            state <= ST_RA;
          end else begin
            bcnt  <= bcnt + SB_W'(1);
            state <= ST_KEYRD;
          end
        end
        ST_RA: begin
          l     <= lx;
          state <= ST_RB;
        end
        ST_RB: begin
          l     <= r ^ f;
          r     <= l;
          round <= round + 4'd1;
          state <= (round == 4'd15) ? ST_FIN : ST_RA;
        end
        ST_FIN: begin
          // undo the last swap and apply the two output whitening subkeys
          l     <= r ^ (dir ? subkeys[0] : subkeys[NSUB - 1]);
          r     <= l ^ (dir ? subkeys[1] : subkeys[NSUB - 2]);
          state <= expand ? ST_WRL : ST_OUT;
        end
        ST_WRL: begin
          if (!sb_phase) begin
            subkeys[{didx[SK_W-2:0], 1'b0}] <= l;
          end
          state <= ST_WRR;
        end
        ST_WRR: begin
          if (!sb_phase) begin
            subkeys[{didx[SK_W-2:0], 1'b1}] <= r;
          end
          if (didx == DV_W'(DERIVE_STEPS - 1)) begin
            expand   <= 1'b0;
            out_kind <= 1'b1;
            state    <= ST_OUT;
          end else begin
            didx  <= didx + DV_W'(1);
            round <= '0;
            state <= ST_RA;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_OUT) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && (!m_tvalid || m_tready)) begin
      m_tuser <= out_kind;
      m_tdata <= out_kind ? 64'd0 : {r, l};
    end
  end

  `TSFC_ASSERT(a_key_count_max, clk, rst, key_count <= KC_W'(KEY_BYTES_MAX))
  `TSFC_ASSERT(a_out_waits, clk, rst, (state == ST_OUT && m_tvalid && !m_tready) |=> (state == ST_OUT))
  `TSFC_ASSERT(a_fin_after_rounds, clk, rst, (state == ST_FIN) |-> ($past(state) == ST_RB && round == 4'd0))
  `TSFC_ASSERT(a_derive_bound, clk, rst, wr_phase |-> (didx < DV_W'(DERIVE_STEPS)))

endmodule

// File: src/two_sbox_feistel_block_cipher.sv
`timescale 1ns / 1ps
// Block request: the core pops the request from the queue head, runs 16 rounds
//   (each a table read state and a compute state), then a final and an output state.
// Key byte: taken from the queue head while idle. Final key byte: reload of the
//   256-entry S-box tables, key schedule mix, 265 chained encipherments.
// Reset: synchronous; after reset the S-box RAMs are reloaded and s_tready stays
//   low meanwhile; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// two_sbox_feistel_block_cipher
// 64-bit, 16-round Feistel cipher with two S-boxes and loadable key.
// ----------------------------------------------------------------------------
module two_sbox_feistel_block_cipher
  import tsfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // key_byte[7:0], left_in[39:8], right_in[71:40]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  input  logic        s_tlast,   // key_last
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // left_out[31:0], right_out[63:32]
  output logic        m_tuser,   // kind
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic    old_key_schedule;
  logic    push;
  cmd_t    push_cmd;
  logic    q_pop;
  cmd_t    q_cmd;
  q_stat_t q_stat;
  logic    clearing;

  // register port: one bit, writes land in the access phase
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_OLD_KEY_SCHEDULE) ? {31'd0, old_key_schedule} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      old_key_schedule <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == ADDR_OLD_KEY_SCHEDULE)) begin
      old_key_schedule <= pwdata[0];
    end
  end

  // front end: decode mode, drop unused codes, feed the queue
  tsfc_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_stat   (q_stat),
    .clearing (clearing),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decouple input handshake from the long-running core
  tsfc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (q_cmd),
    .stat     (q_stat)
  );

  // core: rounds, key schedule, table derivation and result register
  tsfc_core u_core (
    .clk              (clk),
    .rst              (rst),
    .old_key_schedule (old_key_schedule),
    .q_stat           (q_stat),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop),
    .clearing         (clearing),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tuser          (m_tuser)
  );

endmodule
